// File: rtl/core/rar_pkg.sv
package rar_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int RES_WIDTH         = 33;
  localparam int STATUS_WIDTH      = 3;
  localparam int OPCODE_WIDTH      = 8;

  // ASCII operator codes.
  localparam logic [OPCODE_WIDTH-1:0] OP_MUL = 8'd42;
  localparam logic [OPCODE_WIDTH-1:0] OP_ADD = 8'd43;
  localparam logic [OPCODE_WIDTH-1:0] OP_SUB = 8'd45;
  localparam logic [OPCODE_WIDTH-1:0] OP_DIV = 8'd47;

  // Result status codes.
  localparam logic [STATUS_WIDTH-1:0] ST_INV = 3'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_MUL = 3'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_DIV = 3'd2;
  localparam logic [STATUS_WIDTH-1:0] ST_ADD = 3'd3;
  localparam logic [STATUS_WIDTH-1:0] ST_SUB = 3'd4;

endpackage

// File: rtl/core/rational_arith_reduce_unit_top.sv
// Rational arithmetic unit: combines two signed fractions under an ASCII operator ('*', '/',
// '+', '-') and returns the unreduced result and a reduced form with a non-negative
// denominator. One request is worked on at a time by a sequencer that drives one shared
// serial unit: a shift-add multiplier and a restoring divider that each retire one bit per
// cycle, and a binary GCD that does one shift or subtract per cycle. The internal width is
// MW = max(2*OPERAND_WIDTH, 33); every multiply or divide step launches the unit, runs its
// bit steps and captures the result. A multiply or divide request takes two multiplications
// plus, for the reduction, one GCD and two divisions. An add or subtract request also forms
// the least common multiple of the denominators (one more GCD, a division and a
// multiplication) and two scale factors and two scaled numerators; equal denominators and
// zero parts shorten that. An unknown operator answers with status zero and all results
// zero. A new request is taken while the previous result still waits in the output
// register.
module rational_arith_reduce_unit_top #(
  parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [rar_pkg::OPCODE_WIDTH-1:0]        in_req_type,
  input  logic signed [OPERAND_WIDTH-1:0]         in_a_num,
  input  logic signed [OPERAND_WIDTH-1:0]         in_a_den,
  input  logic signed [OPERAND_WIDTH-1:0]         in_b_num,
  input  logic signed [OPERAND_WIDTH-1:0]         in_b_den,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [rar_pkg::STATUS_WIDTH-1:0]        out_status,
  output logic signed [rar_pkg::RES_WIDTH-1:0]    out_raw_num,
  output logic signed [rar_pkg::RES_WIDTH-1:0]    out_raw_den,
  output logic signed [rar_pkg::RES_WIDTH-1:0]    out_red_num,
  output logic signed [rar_pkg::RES_WIDTH-1:0]    out_red_den
);
  import rar_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int RW = RES_WIDTH;
  // Internal width: holds every product modulo the result width and the exact common multiple.
  localparam int MW = (2 * W > RW) ? 2 * W : RW;
  localparam int CW = $clog2(MW + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_P1, S_P2, S_LCM, S_LG, S_LQ, S_LM, S_SCA, S_SCB, S_TA, S_TB,
    S_RED, S_RG, S_RN, S_RD, S_DONE
  } state_t;

  typedef enum logic [1:0] {U_MUL, U_DIV, U_GCD} unit_t;

  state_t state_r;
  logic   busy_r;
  unit_t  unit_r;

  // Shared serial unit registers.
  logic [MW:0]   uacc_r, uacc_s;
  logic [MW-1:0] ua_r, ua_s, ub_r, ub_s;
  logic [CW-1:0] ucnt_r, ucnt_s, uk_r, uk_s;
  logic          u_done;
  logic [MW-1:0] u_res;
  logic [MW:0]   div_t;
  logic          div_ge;

  // Launch operands for the current state.
  unit_t         l_unit;
  logic [MW-1:0] l_a, l_b;

  // Request and working registers.
  logic [STATUS_WIDTH-1:0] st_r;
  logic [MW-1:0] an_r, ad_r, bn_r, bd_r;
  logic [MW-1:0] dmag_r, g_r, sa_r, sb_r;
  logic          dneg_r, nneg_r;
  logic [RW-1:0] ta_r, rn_r, rd_r, mn_r, md_r, rnum_r, rden_r;

  // Output register.
  logic                    out_valid_r;
  logic [STATUS_WIDTH-1:0] out_status_r;
  logic [RW-1:0]           out_raw_num_r, out_raw_den_r, out_red_num_r, out_red_den_r;
  logic                    out_load;

  // Derived combinational values.
  logic [MW-1:0] ad_mag, bd_mag, q_signed_a, q_signed_b, dd_signed;
  logic [RW-1:0] tb_w, rn_sum;
  logic [RW:0]   n_x, d_x, nn_x, dd_x, mn_x;
  logic          flip;
  logic [RW-1:0] mq_signed;

  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_raw_num = out_raw_num_r;
  assign out_raw_den = out_raw_den_r;
  assign out_red_num = out_red_num_r;
  assign out_red_den = out_red_den_r;

  // A finished request moves into the output register once that register is free or
  // its request leaves at the same edge.
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // One step of the shared unit.
  always_comb begin
    uacc_s = uacc_r;
    ua_s   = ua_r;
    ub_s   = ub_r;
    ucnt_s = ucnt_r;
    uk_s   = uk_r;
    div_t  = {uacc_r[MW-1:0], ua_r[MW-1]};
    div_ge = (div_t >= {1'b0, ub_r});
    unique case (unit_r)
      U_MUL: begin
        uacc_s = uacc_r + (ub_r[0] ? {1'b0, ua_r} : '0);
        ua_s   = ua_r << 1;
        ub_s   = ub_r >> 1;
        ucnt_s = ucnt_r - 1'b1;
      end
      U_DIV: begin
        uacc_s = div_ge ? (div_t - {1'b0, ub_r}) : div_t;
        ua_s   = {ua_r[MW-2:0], div_ge};
        ucnt_s = ucnt_r - 1'b1;
      end
      U_GCD: begin
        if (!ua_r[0] && !ub_r[0]) begin
          ua_s = ua_r >> 1;
          ub_s = ub_r >> 1;
          uk_s = uk_r + 1'b1;
        end else if (!ua_r[0]) begin
          ua_s = ua_r >> 1;
        end else if (!ub_r[0]) begin
          ub_s = ub_r >> 1;
        end else if (ua_r > ub_r) begin
          ua_s = ua_r - ub_r;
        end else begin
          ub_s = ub_r - ua_r;
        end
      end
      default: begin
        uacc_s = uacc_r;
      end
    endcase
    if (unit_r == U_GCD) begin
      u_done = (ua_r == ub_r) && ua_r[0];
      u_res  = ua_r << uk_r;
    end else begin
      u_done = (ucnt_r == '0);
      u_res  = (unit_r == U_MUL) ? uacc_r[MW-1:0] : ua_r;
    end
  end

  // Datapath values used by the sequencer.
  always_comb begin
    ad_mag     = ad_r[MW-1] ? (MW'(0) - ad_r) : ad_r;
    bd_mag     = bd_r[MW-1] ? (MW'(0) - bd_r) : bd_r;
    q_signed_a = (dneg_r ^ ad_r[MW-1]) ? (MW'(0) - u_res) : u_res;
    q_signed_b = (dneg_r ^ bd_r[MW-1]) ? (MW'(0) - u_res) : u_res;
    dd_signed  = dneg_r ? (MW'(0) - dmag_r) : dmag_r;
    tb_w       = u_res[RW-1:0];
    rn_sum     = (st_r == ST_ADD) ? (ta_r + tb_w) : (ta_r - tb_w);
    // The reduction moves a negative denominator's sign to the numerator.
    n_x        = {rn_r[RW-1], rn_r};
    d_x        = {rd_r[RW-1], rd_r};
    flip       = rd_r[RW-1];
    nn_x       = flip ? ((RW + 1)'(0) - n_x) : n_x;
    dd_x       = flip ? ((RW + 1)'(0) - d_x) : d_x;
    mn_x       = nn_x[RW] ? ((RW + 1)'(0) - nn_x) : nn_x;
    mq_signed  = nneg_r ? (RW'(0) - u_res[RW-1:0]) : u_res[RW-1:0];
  end

  // Operands handed to the shared unit in each working state.
  always_comb begin
    l_unit = U_MUL;
    l_a    = '0;
    l_b    = '0;
    case (state_r)
      S_P1: begin
        l_a = an_r;
        l_b = (st_r == ST_MUL) ? bn_r : bd_r;
      end
      S_P2: begin
        l_a = ad_r;
        l_b = (st_r == ST_MUL) ? bd_r : bn_r;
      end
      S_LG: begin
        l_unit = U_GCD;
        l_a    = ad_mag;
        l_b    = bd_mag;
      end
      S_LQ: begin
        l_unit = U_DIV;
        l_a    = ad_mag;
        l_b    = g_r;
      end
      S_LM: begin
        l_a = g_r;
        l_b = bd_mag;
      end
      S_SCA: begin
        l_unit = U_DIV;
        l_a    = dmag_r;
        l_b    = ad_mag;
      end
      S_SCB: begin
        l_unit = U_DIV;
        l_a    = dmag_r;
        l_b    = bd_mag;
      end
      S_TA: begin
        l_a = an_r;
        l_b = sa_r;
      end
      S_TB: begin
        l_a = bn_r;
        l_b = sb_r;
      end
      S_RG: begin
        l_unit = U_GCD;
        l_a    = MW'(mn_r);
        l_b    = MW'(md_r);
      end
      S_RN: begin
        l_unit = U_DIV;
        l_a    = MW'(mn_r);
        l_b    = g_r;
      end
      S_RD: begin
        l_unit = U_DIV;
        l_a    = MW'(md_r);
        l_b    = g_r;
      end
      default: begin
        l_unit = U_MUL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      unit_r      <= U_MUL;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r   <= 1'b1;
        out_status_r  <= st_r;
        out_raw_num_r <= rn_r;
        out_raw_den_r <= rd_r;
        out_red_num_r <= rnum_r;
        out_red_den_r <= rden_r;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      // The shared unit advances one step per cycle while it runs.
      if (busy_r && !u_done) begin
        uacc_r <= uacc_s;
        ua_r   <= ua_s;
        ub_r   <= ub_s;
        ucnt_r <= ucnt_s;
        uk_r   <= uk_s;
      end

      // Working states launch the unit once, then capture its result when it finishes.
      if (state_r != S_IDLE && state_r != S_LCM && state_r != S_RED && state_r != S_DONE
          && !busy_r) begin
        // A scale factor over a zero denominator is zero and needs no division.
        if (state_r == S_SCA && ad_mag == '0) begin
          sa_r    <= '0;
          state_r <= S_SCB;
        end else if (state_r == S_SCB && bd_mag == '0) begin
          sb_r    <= '0;
          state_r <= S_TA;
        end else begin
          busy_r <= 1'b1;
          unit_r <= l_unit;
          uacc_r <= '0;
          ua_r   <= l_a;
          ub_r   <= l_b;
          uk_r   <= '0;
          ucnt_r <= CW'(MW);
        end
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            an_r   <= {{(MW - W){in_a_num[W-1]}}, in_a_num};
            ad_r   <= {{(MW - W){in_a_den[W-1]}}, in_a_den};
            bn_r   <= {{(MW - W){in_b_num[W-1]}}, in_b_num};
            bd_r   <= {{(MW - W){in_b_den[W-1]}}, in_b_den};
            unique case (in_req_type)
              OP_MUL: begin
                st_r    <= ST_MUL;
                state_r <= S_P1;
              end
              OP_DIV: begin
                st_r    <= ST_DIV;
                state_r <= S_P1;
              end
              OP_ADD: begin
                st_r    <= ST_ADD;
                state_r <= S_LCM;
              end
              OP_SUB: begin
                st_r    <= ST_SUB;
                state_r <= S_LCM;
              end
              default: begin
                st_r    <= ST_INV;
                rn_r    <= '0;
                rd_r    <= '0;
                rnum_r  <= '0;
                rden_r  <= '0;
                state_r <= S_DONE;
              end
            endcase
          end
        end
        S_P1: begin
          if (busy_r && u_done) begin
            rn_r    <= u_res[RW-1:0];
            busy_r  <= 1'b0;
            state_r <= S_P2;
          end
        end
        S_P2: begin
          if (busy_r && u_done) begin
            rd_r    <= u_res[RW-1:0];
            busy_r  <= 1'b0;
            state_r <= S_RED;
          end
        end
        S_LCM: begin
          // Equal denominators are used as they are, sign included.
          if (ad_r == bd_r) begin
            dmag_r  <= ad_mag;
            dneg_r  <= ad_r[MW-1];
            state_r <= S_SCA;
          end else if (ad_mag == '0 || bd_mag == '0) begin
            dmag_r  <= '0;
            dneg_r  <= 1'b0;
            state_r <= S_SCA;
          end else begin
            dneg_r  <= 1'b0;
            state_r <= S_LG;
          end
        end
        S_LG: begin
          if (busy_r && u_done) begin
            g_r     <= u_res;
            busy_r  <= 1'b0;
            state_r <= S_LQ;
          end
        end
        S_LQ: begin
          if (busy_r && u_done) begin
            g_r     <= u_res;
            busy_r  <= 1'b0;
            state_r <= S_LM;
          end
        end
        S_LM: begin
          if (busy_r && u_done) begin
            dmag_r  <= u_res;
            busy_r  <= 1'b0;
            state_r <= S_SCA;
          end
        end
        S_SCA: begin
          if (busy_r && u_done) begin
            sa_r    <= q_signed_a;
            busy_r  <= 1'b0;
            state_r <= S_SCB;
          end
        end
        S_SCB: begin
          if (busy_r && u_done) begin
            sb_r    <= q_signed_b;
            busy_r  <= 1'b0;
            state_r <= S_TA;
          end
        end
        S_TA: begin
          if (busy_r && u_done) begin
            ta_r    <= u_res[RW-1:0];
            busy_r  <= 1'b0;
            state_r <= S_TB;
          end
        end
        S_TB: begin
          if (busy_r && u_done) begin
            rn_r    <= rn_sum;
            rd_r    <= dd_signed[RW-1:0];
            busy_r  <= 1'b0;
            state_r <= S_RED;
          end
        end
        S_RED: begin
          mn_r   <= mn_x[RW-1:0];
          md_r   <= dd_x[RW-1:0];
          nneg_r <= nn_x[RW];
          // With a zero part only the sign move applies.
          if (mn_x == '0 || dd_x == '0) begin
            rnum_r  <= nn_x[RW-1:0];
            rden_r  <= dd_x[RW-1:0];
            state_r <= S_DONE;
          end else begin
            state_r <= S_RG;
          end
        end
        S_RG: begin
          if (busy_r && u_done) begin
            g_r     <= u_res;
            busy_r  <= 1'b0;
            state_r <= S_RN;
          end
        end
        S_RN: begin
          if (busy_r && u_done) begin
            rnum_r  <= mq_signed;
            busy_r  <= 1'b0;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          if (busy_r && u_done) begin
            rden_r  <= u_res[RW-1:0];
            busy_r  <= 1'b0;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: tb/sv/rational_arith_reduce_unit_top_tb.sv
module rational_arith_reduce_unit_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rar_pkg::*;

  localparam int OW = OPERAND_WIDTH_DEF;

  // One request to the block and the result it should produce.
  typedef struct packed {
    logic [OPCODE_WIDTH-1:0] op;
    logic signed [OW-1:0]    an;
    logic signed [OW-1:0]    ad;
    logic signed [OW-1:0]    bn;
    logic signed [OW-1:0]    bd;
  } frac_req_t;

  typedef struct packed {
    logic [STATUS_WIDTH-1:0]     status;
    logic signed [RES_WIDTH-1:0] raw_num;
    logic signed [RES_WIDTH-1:0] raw_den;
    logic signed [RES_WIDTH-1:0] red_num;
    logic signed [RES_WIDTH-1:0] red_den;
  } frac_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OPCODE_WIDTH-1:0] in_req_type = '0;
  logic signed [OW-1:0] in_a_num = '0;
  logic signed [OW-1:0] in_a_den = '0;
  logic signed [OW-1:0] in_b_num = '0;
  logic signed [OW-1:0] in_b_den = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STATUS_WIDTH-1:0] out_status;
  logic signed [RES_WIDTH-1:0] out_raw_num, out_raw_den, out_red_num, out_red_den;

  // Random idling is switched off for a long stretch in the middle of the run.
  bit quiet_stretch = 1'b0;
  int unsigned mismatch_count = 0;
  frac_res_t expected_results[$];

  always #4 clk = ~clk;

  rational_arith_reduce_unit_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .in_a_num(in_a_num), .in_a_den(in_a_den), .in_b_num(in_b_num), .in_b_den(in_b_den),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_raw_num(out_raw_num), .out_raw_den(out_raw_den),
    .out_red_num(out_red_num), .out_red_den(out_red_den)
  );

  function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic longint unsigned mag64(longint signed v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  // Scale factor common/den used to lift a fraction to the common denominator.
  // A zero denominator gives a zero factor.
  function automatic longint signed lift_factor(longint signed common, longint signed den);
    longint unsigned q;
    if (den == 0) return 0;
    q = mag64(common) / mag64(den);
    return ((common < 0) != (den < 0)) ? -longint'(q) : longint'(q);
  endfunction

  // Computes the raw and reduced fraction for one request.
  function automatic frac_res_t combine_fractions(frac_req_t r);
    frac_res_t res;
    longint signed an, ad, bn, bd, rn, rd, n, d, common;
    longint unsigned mn, md, g;
    an = r.an; ad = r.ad; bn = r.bn; bd = r.bd;
    res = '0;
    case (r.op) inside
      OP_MUL: begin
        res.status = ST_MUL; rn = an * bn; rd = ad * bd;
      end
      OP_DIV: begin
        res.status = ST_DIV; rn = an * bd; rd = ad * bn;
      end
      OP_ADD, OP_SUB: begin
        // Equal denominators keep their sign; a zero denominator gives zero; otherwise use the positive LCM.
        if (ad == bd) common = ad;
        else if (ad == 0 || bd == 0) common = 0;
        else common = longint'((mag64(ad) / gcd64(mag64(ad), mag64(bd))) * mag64(bd));
        res.status = (r.op == OP_ADD) ? ST_ADD : ST_SUB;
        rn = (r.op == OP_ADD) ? an * lift_factor(common, ad) + bn * lift_factor(common, bd)
                              : an * lift_factor(common, ad) - bn * lift_factor(common, bd);
        rd = common;
      end
      default: return res;
    endcase
    res.raw_num = rn[RES_WIDTH-1:0];
    res.raw_den = rd[RES_WIDTH-1:0];
    n = res.raw_num;
    d = res.raw_den;
    // A negative denominator hands its sign to the numerator.
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    mn = mag64(n);
    md = mag64(d);
    if (mn != 0 && md != 0) begin
      g = gcd64(mn, md);
      n = (n < 0) ? -longint'(mn / g) : longint'(mn / g);
      d = (d < 0) ? -longint'(md / g) : longint'(md / g);
    end
    res.red_num = n[RES_WIDTH-1:0];
    res.red_den = d[RES_WIDTH-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatch_count++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // Sends one request and records its expected result when it is accepted. Valid stays
  // high from one request to the next unless the sender idles.
  task automatic send_request(frac_req_t r);
    while (!quiet_stretch && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= r.op;
    in_a_num <= r.an;
    in_a_den <= r.ad;
    in_b_num <= r.bn;
    in_b_den <= r.bd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(combine_fractions(r));
  endtask

  function automatic logic signed [OW-1:0] rand_operand();
    case ($urandom_range(5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return OW'($signed($urandom_range(17)) - 8);
      default: return OW'($urandom);
    endcase
  endfunction

  function automatic frac_req_t rand_request();
    frac_req_t r;
    case ($urandom_range(19)) inside
      0: r.op = OPCODE_WIDTH'($urandom);
      [1:4]: r.op = OP_MUL;
      [5:8]: r.op = OP_DIV;
      [9:13]: r.op = OP_ADD;
      default: r.op = OP_SUB;
    endcase
    r.an = rand_operand();
    r.ad = rand_operand();
    r.bn = rand_operand();
    // Equal denominators take their own path in add and subtract.
    r.bd = ($urandom_range(4) == 0) ? r.ad : rand_operand();
    return r;
  endfunction

  function automatic frac_req_t mk(logic [OPCODE_WIDTH-1:0] op, int an, int ad, int bn,
                                   int bd);
    frac_req_t r;
    r.op = op; r.an = OW'(an); r.ad = OW'(ad); r.bn = OW'(bn); r.bd = OW'(bd);
    return r;
  endfunction

  // Every operation at the field extremes, sign moves and zero parts.
  task automatic test_directed_ops();
    send_request(mk(OP_MUL, 3, 4, 2, 9));
    send_request(mk(OP_MUL, -32768, -32768, -32768, -32768));
    send_request(mk(OP_MUL, 32767, -32768, 32767, 32767));
    send_request(mk(OP_MUL, 0, 5, 7, 3));
    send_request(mk(OP_DIV, 1, 2, 3, 4));
    send_request(mk(OP_DIV, -32768, 32767, 32767, -32768));
    send_request(mk(OP_DIV, 5, 7, 0, 3));
    send_request(mk(OP_ADD, 1, 6, 1, 10));
    send_request(mk(OP_ADD, 32767, -5, 32767, -5));
    send_request(mk(OP_ADD, -32768, 32767, -32768, -32768));
    send_request(mk(OP_ADD, 1, 0, 2, 3));
    send_request(mk(OP_ADD, 1, 0, 2, 0));
    send_request(mk(OP_SUB, 1, 3, 1, 3));
    send_request(mk(OP_SUB, -32768, -32768, 32767, 32767));
    send_request(mk(OP_SUB, 4, 5, 2, 0));
  endtask

  // Unknown operators answer with status zero and zero results.
  task automatic test_invalid_ops();
    send_request(mk(8'd0, 1, 2, 3, 4));
    send_request(mk(8'd255, -1, -1, -1, -1));
    send_request(mk(8'd44, 7, 7, 7, 7));
    send_request(mk(8'd46, 2, 3, 4, 5));
  endtask

  task automatic test_random_mix(int count);
    for (int i = 0; i < count; i++) begin
      quiet_stretch = (i >= count / 3) && (i < count / 2);
      send_request(rand_request());
    end
    quiet_stretch = 1'b0;
  endtask

  // Result side: random stall, and each accepted result is checked against the
  // oldest expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", out_status, 0);
        end else begin
          frac_res_t want;
          want = expected_results.pop_front();
          if (out_status !== want.status) report_mismatch("status", out_status, want.status);
          if (out_raw_num !== want.raw_num) report_mismatch("raw_num", out_raw_num, want.raw_num);
          if (out_raw_den !== want.raw_den) report_mismatch("raw_den", out_raw_den, want.raw_den);
          if (out_red_num !== want.red_num) report_mismatch("red_num", out_red_num, want.red_num);
          if (out_red_den !== want.red_den) report_mismatch("red_den", out_red_den, want.red_den);
        end
      end
      out_stall <= !quiet_stretch && ($urandom_range(99) < 7);
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_ops();
    test_invalid_ops();
    test_random_mix(750);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("** rational_arith_reduce_unit_top: PASSED **");
    end else begin
      $display("** rational_arith_reduce_unit_top: FAILED **");
    end
    $finish;
  end

  // Time limit for the whole run, with ample room for the worst case and stalls.
  initial begin
    #20ms;
    $display("** rational_arith_reduce_unit_top: FAILED **");
    $finish;
  end
endmodule
